// ===== sv/json_syntax_checker_top_assert.svh =====
// Assertion macros used by the checker's nesting stack.
`ifndef JSON_SYNTAX_CHECKER_TOP_ASSERT_SVH
`define JSON_SYNTAX_CHECKER_TOP_ASSERT_SVH

// cond must never hold at a clock edge outside reset
`define JSC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define JSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/jsc_pkg.sv =====
// Shared constants, types and character classes of the syntax checker.
package jsc_pkg;

  localparam int NEST_DEPTH_DEF = 64;
  localparam int CNT_W = 24;
  localparam logic [CNT_W-1:0] COUNT_MAX = 24'hFFFFFF;

  // status codes
  localparam logic [3:0] ST_OK         = 4'd0;
  localparam logic [3:0] ST_VALID      = 4'd1;
  localparam logic [3:0] ST_BAD_FIRST  = 4'd2;
  localparam logic [3:0] ST_TRAILING   = 4'd3;
  localparam logic [3:0] ST_UNEXPECTED = 4'd4;
  localparam logic [3:0] ST_MISMATCH   = 4'd5;
  localparam logic [3:0] ST_EXTRA      = 4'd6;
  localparam logic [3:0] ST_UNCLOSED   = 4'd7;
  localparam logic [3:0] ST_TOO_DEEP   = 4'd8;

  // expected character classes
  localparam logic [3:0] X_OPEN     = 4'd0;
  localparam logic [3:0] X_NUMTAIL  = 4'd1;
  localparam logic [3:0] X_VALUE    = 4'd2;
  localparam logic [3:0] X_OBJAFTER = 4'd3;
  localparam logic [3:0] X_ARRAFTER = 4'd4;
  localparam logic [3:0] X_DIGIT    = 4'd5;
  localparam logic [3:0] X_R        = 4'd6;
  localparam logic [3:0] X_U        = 4'd7;
  localparam logic [3:0] X_E        = 4'd8;
  localparam logic [3:0] X_A        = 4'd9;
  localparam logic [3:0] X_L        = 4'd10;
  localparam logic [3:0] X_S        = 4'd11;
  localparam logic [3:0] X_QUOTE    = 4'd12;
  localparam logic [3:0] X_NOTHING  = 4'd13;
  localparam logic [3:0] X_COLON    = 4'd14;

  // previous tokens
  localparam logic [3:0] T_NONE     = 4'd0;
  localparam logic [3:0] T_LBRACE   = 4'd1;
  localparam logic [3:0] T_LBRACKET = 4'd2;
  localparam logic [3:0] T_QUOTE    = 4'd3;
  localparam logic [3:0] T_COLON    = 4'd4;
  localparam logic [3:0] T_COMMA    = 4'd5;
  localparam logic [3:0] T_RBRACE   = 4'd6;
  localparam logic [3:0] T_RBRACKET = 4'd7;
  localparam logic [3:0] T_NUMBER   = 4'd8;
  localparam logic [3:0] T_LIT      = 4'd9;
  localparam logic [3:0] T_N        = 4'd10;
  localparam logic [3:0] T_A        = 4'd11;
  localparam logic [3:0] T_U        = 4'd12;
  localparam logic [3:0] T_L        = 4'd13;

  // characters
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LE     = 8'h65;
  localparam logic [7:0] CH_LF_F   = 8'h66;
  localparam logic [7:0] CH_LL     = 8'h6C;
  localparam logic [7:0] CH_LN     = 8'h6E;
  localparam logic [7:0] CH_LR     = 8'h72;
  localparam logic [7:0] CH_LS     = 8'h73;
  localparam logic [7:0] CH_LT     = 8'h74;
  localparam logic [7:0] CH_LU     = 8'h75;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // stack command from the scanner
  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic brace;
  } stack_cmd_t;

  // stack top view: top entry and the one below it
  typedef struct packed {
    logic top;
    logic under;
  } stack_view_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  function automatic logic in_class(logic [3:0] cls, logic [7:0] b);
    logic dig;
    dig = is_digit(b);
    case (cls)
      X_OPEN:     return b == CH_LBRACE;
      X_NUMTAIL:  return dig || b == CH_DOT || b == CH_COMMA || b == CH_RBRACK ||
                         b == CH_RBRACE;
      X_VALUE:    return dig || b == CH_LBRACK || b == CH_LBRACE || b == CH_PLUS ||
                         b == CH_MINUS || b == CH_DOT || b == CH_LT || b == CH_LF_F ||
                         b == CH_LN || b == CH_DQUOTE;
      X_OBJAFTER: return b == CH_COMMA || b == CH_RBRACE;
      X_ARRAFTER: return b == CH_COMMA || b == CH_RBRACK;
      X_DIGIT:    return dig;
      X_R:        return b == CH_LR;
      X_U:        return b == CH_LU;
      X_E:        return b == CH_LE;
      X_A:        return b == CH_LA;
      X_L:        return b == CH_LL;
      X_S:        return b == CH_LS;
      X_QUOTE:    return b == CH_DQUOTE;
      X_COLON:    return b == CH_COLON;
      default:    return 1'b0;
    endcase
  endfunction

endpackage

// ===== sv/json_syntax_checker_top.sv =====
// Byte-serial checker for a loose JSON dialect with a memory-held nesting stack.
// Result: registered, and shown in the cycle after its byte is transferred.
// Throughput: one byte per cycle unless stalled; stack memory prefetches below the top.
// Output register: a new byte is taken while the last result waits, if out_ready is high.
// Reset (rst, synchronous): clears counters, error and stack depth; memory is not cleared.
// An end item gives the verdict and clears the same state in the same cycle.
module json_syntax_checker_top #(
  parameter int NEST_DEPTH = jsc_pkg::NEST_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [23:0] line_number,
  output logic [23:0] column_number
);

  localparam int DW = $clog2(NEST_DEPTH + 1);
  localparam int CW = jsc_pkg::CNT_W;

  logic [DW-1:0] depth;
  jsc_pkg::stack_view_t view;
  jsc_pkg::stack_cmd_t  cmd_c;
  jsc_pkg::stack_cmd_t  cmd;

  logic [3:0]    expc, expc_next;
  logic [3:0]    prevt, prevt_next;
  logic          vside, vside_next;
  logic          instr, instr_next;
  logic          seen, seen_next;
  logic [3:0]    err, err_next;
  logic [CW-1:0] line_cnt, line_cnt_next;
  logic [CW-1:0] col_cnt, col_cnt_next;
  logic [3:0]    res_status;

  logic          accept;
  logic          ws;
  logic          tob;
  logic [3:0]    av;
  logic [3:0]    e;
  logic [CW-1:0] col_inc;
  logic          closer;
  logic          close_brace;

  assign accept = in_valid && in_ready;
  assign in_ready = !out_valid || out_ready;

  always_comb begin
    expc_next     = expc;
    prevt_next    = prevt;
    vside_next    = vside;
    instr_next    = instr;
    seen_next     = seen;
    err_next      = err;
    line_cnt_next = line_cnt;
    col_cnt_next  = col_cnt;
    cmd_c         = '0;
    e             = jsc_pkg::ST_OK;
    res_status    = err;
    ws  = text_byte == jsc_pkg::CH_SPACE || text_byte == jsc_pkg::CH_LF ||
          text_byte == jsc_pkg::CH_TAB;
    tob = view.top;
    av  = tob ? jsc_pkg::X_OBJAFTER : jsc_pkg::X_ARRAFTER;
    col_inc = (col_cnt < jsc_pkg::COUNT_MAX) ? col_cnt + CW'(1) : col_cnt;
    closer = text_byte == jsc_pkg::CH_RBRACE || text_byte == jsc_pkg::CH_RBRACK;
    close_brace = text_byte == jsc_pkg::CH_RBRACE;

    if (end_of_text) begin
      if (err != jsc_pkg::ST_OK) begin
        res_status = err;
      end else if (!seen) begin
        res_status = jsc_pkg::ST_BAD_FIRST;
      end else if (depth != '0) begin
        res_status = jsc_pkg::ST_UNCLOSED;
      end else begin
        res_status = jsc_pkg::ST_VALID;
      end
      expc_next     = jsc_pkg::X_OPEN;
      prevt_next    = jsc_pkg::T_NONE;
      vside_next    = 1'b0;
      instr_next    = 1'b0;
      seen_next     = 1'b0;
      err_next      = jsc_pkg::ST_OK;
      line_cnt_next = CW'(1);
      col_cnt_next  = '0;
      cmd_c.clear   = 1'b1;
    end else if (err == jsc_pkg::ST_OK) begin
      if (!ws) begin
        seen_next = 1'b1;
        if (!seen && text_byte != jsc_pkg::CH_LBRACE) begin
          e = jsc_pkg::ST_BAD_FIRST;
        end else if (expc == jsc_pkg::X_NOTHING) begin
          e = jsc_pkg::ST_TRAILING;
        end
      end
      if (e == jsc_pkg::ST_OK) begin
        if (instr) begin
          if (text_byte == jsc_pkg::CH_DQUOTE) begin
            instr_next = 1'b0;
            prevt_next = jsc_pkg::T_QUOTE;
            if (tob) begin
              expc_next = vside ? jsc_pkg::X_OBJAFTER : jsc_pkg::X_COLON;
            end else begin
              expc_next = jsc_pkg::X_ARRAFTER;
            end
          end
        end else if (!ws) begin
          if (!jsc_pkg::in_class(expc, text_byte)) begin
            e = jsc_pkg::ST_UNEXPECTED;
          end else if (jsc_pkg::is_digit(text_byte)) begin
            prevt_next = jsc_pkg::T_NUMBER;
            expc_next  = jsc_pkg::X_NUMTAIL;
          end else if (closer) begin
            if (depth == '0) begin
              e = jsc_pkg::ST_EXTRA;
            end else if (tob != close_brace) begin
              e = jsc_pkg::ST_MISMATCH;
            end else begin
              cmd_c.pop  = 1'b1;
              prevt_next = close_brace ? jsc_pkg::T_RBRACE : jsc_pkg::T_RBRACKET;
              if (depth == DW'(1)) begin
                expc_next = jsc_pkg::X_NOTHING;
              end else begin
                expc_next = view.under ? jsc_pkg::X_OBJAFTER : jsc_pkg::X_ARRAFTER;
              end
            end
          end else begin
            case (text_byte)
              jsc_pkg::CH_LBRACE: begin
                if (depth == DW'(NEST_DEPTH)) begin
                  e = jsc_pkg::ST_TOO_DEEP;
                end else begin
                  cmd_c.push  = 1'b1;
                  cmd_c.brace = 1'b1;
                  prevt_next  = jsc_pkg::T_LBRACE;
                  expc_next   = jsc_pkg::X_QUOTE;
                  vside_next  = 1'b0;
                end
              end
              jsc_pkg::CH_LBRACK: begin
                if (depth == DW'(NEST_DEPTH)) begin
                  e = jsc_pkg::ST_TOO_DEEP;
                end else begin
                  cmd_c.push = 1'b1;
                  prevt_next = jsc_pkg::T_LBRACKET;
                  expc_next  = jsc_pkg::X_VALUE;
                end
              end
              jsc_pkg::CH_DQUOTE: begin
                instr_next = 1'b1;
                prevt_next = jsc_pkg::T_QUOTE;
                expc_next  = jsc_pkg::X_QUOTE;
              end
              jsc_pkg::CH_COLON: begin
                prevt_next = jsc_pkg::T_COLON;
                expc_next  = jsc_pkg::X_VALUE;
                vside_next = 1'b1;
              end
              jsc_pkg::CH_COMMA: begin
                prevt_next = jsc_pkg::T_COMMA;
                if (tob) begin
                  expc_next  = jsc_pkg::X_QUOTE;
                  vside_next = 1'b0;
                end else begin
                  expc_next = jsc_pkg::X_VALUE;
                end
              end
              jsc_pkg::CH_PLUS, jsc_pkg::CH_MINUS, jsc_pkg::CH_DOT: begin
                prevt_next = jsc_pkg::T_NUMBER;
                expc_next  = jsc_pkg::X_DIGIT;
              end
              jsc_pkg::CH_LT: begin
                prevt_next = jsc_pkg::T_LIT;
                expc_next  = jsc_pkg::X_R;
              end
              jsc_pkg::CH_LR: begin
                prevt_next = jsc_pkg::T_LIT;
                expc_next  = jsc_pkg::X_U;
              end
              jsc_pkg::CH_LU: begin
                expc_next  = (prevt == jsc_pkg::T_N) ? jsc_pkg::X_L : jsc_pkg::X_E;
                prevt_next = jsc_pkg::T_U;
              end
              jsc_pkg::CH_LE: begin
                prevt_next = jsc_pkg::T_LIT;
                expc_next  = av;
              end
              jsc_pkg::CH_LF_F: begin
                prevt_next = jsc_pkg::T_LIT;
                expc_next  = jsc_pkg::X_A;
              end
              jsc_pkg::CH_LA: begin
                prevt_next = jsc_pkg::T_A;
                expc_next  = jsc_pkg::X_L;
              end
              jsc_pkg::CH_LL: begin
                if (prevt == jsc_pkg::T_A) begin
                  expc_next = jsc_pkg::X_S;
                end else if (prevt == jsc_pkg::T_U) begin
                  expc_next = jsc_pkg::X_L;
                end else begin
                  expc_next = av;
                end
                prevt_next = jsc_pkg::T_L;
              end
              jsc_pkg::CH_LS: begin
                prevt_next = jsc_pkg::T_LIT;
                expc_next  = jsc_pkg::X_E;
              end
              jsc_pkg::CH_LN: begin
                prevt_next = jsc_pkg::T_N;
                expc_next  = jsc_pkg::X_U;
              end
              default: begin
                e = jsc_pkg::ST_UNEXPECTED;
              end
            endcase
          end
        end
      end

      col_cnt_next = col_inc;
      if (e == jsc_pkg::ST_OK) begin
        if (text_byte == jsc_pkg::CH_LF) begin
          if (line_cnt < jsc_pkg::COUNT_MAX) begin
            line_cnt_next = line_cnt + CW'(1);
          end
          col_cnt_next = '0;
        end
      end else begin
        // error: the column advances and the error and seen flag are recorded; parse state and stack hold
        expc_next  = expc;
        prevt_next = prevt;
        vside_next = vside;
        instr_next = instr;
        cmd_c      = '0;
      end
      err_next   = e;
      res_status = e;
    end
  end

  assign cmd = accept ? cmd_c : '0;

  jsc_stack #(
    .NEST_DEPTH(NEST_DEPTH)
  ) u_stack (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .depth (depth),
    .view  (view)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      expc     <= jsc_pkg::X_OPEN;
      prevt    <= jsc_pkg::T_NONE;
      vside    <= 1'b0;
      instr    <= 1'b0;
      seen     <= 1'b0;
      err      <= jsc_pkg::ST_OK;
      line_cnt <= CW'(1);
      col_cnt  <= '0;
    end else if (accept) begin
      expc     <= expc_next;
      prevt    <= prevt_next;
      vside    <= vside_next;
      instr    <= instr_next;
      seen     <= seen_next;
      err      <= err_next;
      line_cnt <= line_cnt_next;
      col_cnt  <= col_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // end items report the position before clearing
  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= res_status;
      line_number   <= end_of_text ? line_cnt : line_cnt_next;
      column_number <= end_of_text ? col_cnt : col_cnt_next;
    end
  end

endmodule

// ===== sv/jsc_stack.sv =====
// Nesting stack: one-bit entries in a synchronous memory with a cached top.
`include "json_syntax_checker_top_assert.svh"

module jsc_stack #(
  parameter int NEST_DEPTH = jsc_pkg::NEST_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  jsc_pkg::stack_cmd_t               cmd,
  output logic [$clog2(NEST_DEPTH+1)-1:0]   depth,
  output jsc_pkg::stack_view_t              view
);

  localparam int DW = $clog2(NEST_DEPTH + 1);
  localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

  logic          mem [NEST_DEPTH];
  logic [DW-1:0] depth_next;
  logic [DW-1:0] depth_m2;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          rd_data;
  logic          top;

  always_comb begin
    if (cmd.clear) begin
      depth_next = '0;
    end else if (cmd.push) begin
      depth_next = depth + DW'(1);
    end else if (cmd.pop) begin
      depth_next = depth - DW'(1);
    end else begin
      depth_next = depth;
    end
  end

  // prefetch the entry under the next top, so a pop finds its new top ready
  assign depth_m2 = depth_next - DW'(2);
  assign rd_addr  = depth_m2[AW-1:0];
  assign wr_addr  = depth[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.brace;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else begin
      depth <= depth_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top <= cmd.brace;
    end else if (cmd.pop) begin
      top <= rd_data;
    end
  end

  assign view.top   = (depth != '0) && top;
  assign view.under = rd_data;

  `JSC_ASSERT_NEVER(a_no_overflow, cmd.push && depth == DW'(NEST_DEPTH), "push on full stack")
  `JSC_ASSERT_NEVER(a_no_underflow, cmd.pop && depth == '0, "pop on empty stack")
  `JSC_ASSERT_NEVER(a_rw_collide, cmd.push && rd_addr == wr_addr, "read and write collide")
  `JSC_ASSERT_NEXT(a_push_top, cmd.push && !cmd.clear, view.top == $past(cmd.brace), "top lost")
  `JSC_ASSERT_NEXT(a_pop_top, cmd.pop && !cmd.clear && depth > DW'(1),
                   view.top == $past(rd_data), "stale top after pop")

endmodule
